[design/smas_pkg.sv]
// ----------------------------------------------------------------------------
// smas_pkg
// Shared types and constants for the sensor map and smoothing block.
// ----------------------------------------------------------------------------
package smas_pkg;

  // field widths
  localparam int MV_W      = 13;
  localparam int LEVEL_W   = 10;
  localparam int CFG_IDX_W = 3;

  // divider operands: products below 2^23, quotient always below 1024
  localparam int NUM_W  = 23;
  localparam int DEN_W  = 13;
  localparam int QUOT_W = 10;
  localparam int CNT_W  = 4;

  // smoothing arithmetic
  localparam int SUM_W       = 14;
  localparam int SCALE_W     = 27;
  localparam int RECIP_SHIFT = 16;

  localparam logic [LEVEL_W-1:0] SOIL_FULL   = 10'd1000;
  localparam logic [LEVEL_W-1:0] JUMP_LIMIT  = 10'd500;
  // ceil(2^16 / 10); exact floor(x/10) for x below 16384
  localparam logic [12:0]        RECIP_TENTH = 13'd6554;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOIL_WET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOIL_DRY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAT_IN_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAT_IN_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAT_OUT_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BAT_OUT_HI = 3'd5;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

[design/smas_div.sv]
// ----------------------------------------------------------------------------
// smas_div
// Shift-subtract divider, one quotient bit per cycle, for quotients that are
// known to fit in QUOT_W bits (num < 2^QUOT_W * den).
// ----------------------------------------------------------------------------
module smas_div
  import smas_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [QUOT_W-1:0] quot;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic              ge;
  logic [NUM_W-1:0]  diff;

  // trial subtract of the shifted divisor
  always_comb begin
    ge   = rem >= dsh;
    diff = rem - dsh;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      dsh <= NUM_W'(req.den) << (QUOT_W - 1);
    end else if (busy) begin
      if (ge) begin
        rem <= diff;
      end
      quot <= {quot[QUOT_W-2:0], ge};
      dsh  <= dsh >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy)
    else $error("divider did not go busy after start");

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    (busy && !req.start && cnt == '0) |=> (done && !busy))
    else $error("divider missed its done pulse");

endmodule

[design/sensor_map_and_adaptive_smoothing.sv]
// ----------------------------------------------------------------------------
// sensor_map_and_adaptive_smoothing
// Each transaction carries a moisture and a battery reading in millivolts.
// Moisture is clamped to the wet..dry window and mapped inversely onto
// 0..1000 (1000 when the window is empty); battery is clamped and mapped
// onto the configured output range. Each mapped value is then smoothed as
// floor((a*new + (10-a)*old)/10) with a = 9 on a jump above 500, else 2.
// One transaction is processed at a time; from acceptance to a valid result
// it makes two passes through the shared shift-subtract divider (one
// quotient bit per cycle), each after a multiply set-up state, and four
// smoothing states. A battery reading at or outside its
// window bounds, or an empty moisture window, skips that divider pass.
// A finished result waits in the output register; s_tready rises once the
// block is back in idle.
// ----------------------------------------------------------------------------
module sensor_map_and_adaptive_smoothing
  import smas_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [12:0] soil_mv, [25:13] battery_mv
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // [9:0] soil_level, [19:10] battery_level
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MV_W-1:0]      cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SMUL = 10'b0000000010,
    S_SDIV = 10'b0000000100,
    S_BMUL = 10'b0000001000,
    S_BDIV = 10'b0000010000,
    S_SUM0 = 10'b0000100000,
    S_RND0 = 10'b0001000000,
    S_SUM1 = 10'b0010000000,
    S_RND1 = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [MV_W-1:0]    soil_wet_limit;
  logic [MV_W-1:0]    soil_dry_limit;
  logic [MV_W-1:0]    battery_in_low;
  logic [MV_W-1:0]    battery_in_high;
  logic [LEVEL_W-1:0] battery_out_low;
  logic [LEVEL_W-1:0] battery_out_high;

  // item and working registers
  logic [MV_W-1:0]    soil_mv;
  logic [MV_W-1:0]    battery_mv;
  logic [LEVEL_W-1:0] soil_map;
  logic [LEVEL_W-1:0] battery_map;
  logic               bat_neg;
  logic [SUM_W-1:0]   sum;
  logic [LEVEL_W-1:0] soil_smoothed;
  logic [LEVEL_W-1:0] battery_smoothed;

  logic               accept;
  logic               out_load;

  logic               soil_empty;
  logic [MV_W-1:0]    soil_clamp;
  logic [MV_W-1:0]    soil_off;
  logic [NUM_W-1:0]   soil_prod;
  logic [DEN_W-1:0]   soil_den;

  logic               bat_lo_hit;
  logic               bat_hi_hit;
  logic               out_neg;
  logic [LEVEL_W-1:0] out_span;
  logic [MV_W-1:0]    bat_off;
  logic [NUM_W-1:0]   bat_prod;
  logic [DEN_W-1:0]   bat_den;
  logic [LEVEL_W-1:0] bat_div_level;

  logic               sm_sel;
  logic [LEVEL_W-1:0] sm_new;
  logic [LEVEL_W-1:0] sm_old;
  logic [LEVEL_W-1:0] sm_diff;
  logic               sm_fast;
  logic [SUM_W-1:0]   sm_sum;
  logic [SCALE_W-1:0] sm_scaled;
  logic [LEVEL_W-1:0] sm_result;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // moisture map operands
  always_comb begin
    soil_empty = soil_dry_limit <= soil_wet_limit;
    if (soil_mv < soil_wet_limit) begin
      soil_clamp = soil_wet_limit;
    end else if (soil_mv > soil_dry_limit) begin
      soil_clamp = soil_dry_limit;
    end else begin
      soil_clamp = soil_mv;
    end
    soil_off  = soil_clamp - soil_wet_limit;
    soil_prod = NUM_W'(soil_off) * NUM_W'(SOIL_FULL);
    soil_den  = soil_dry_limit - soil_wet_limit;
  end

  // battery map operands, magnitude and sign of the output span
  always_comb begin
    bat_lo_hit = battery_mv <= battery_in_low;
    bat_hi_hit = battery_mv >= battery_in_high;
    out_neg    = battery_out_high < battery_out_low;
    out_span   = out_neg ? (battery_out_low - battery_out_high)
                         : (battery_out_high - battery_out_low);
    bat_off    = battery_mv - battery_in_low;
    bat_prod   = NUM_W'(bat_off) * NUM_W'(out_span);
    bat_den    = battery_in_high - battery_in_low;
    // truncation toward zero: negate the magnitude quotient
    bat_div_level = bat_neg ? (battery_out_low - div_rsp.quot)
                            : (battery_out_low + div_rsp.quot);
  end

  // divider requests
  always_comb begin
    div_req.start = ((state == S_SMUL) && !soil_empty) ||
                    ((state == S_BMUL) && !bat_lo_hit && !bat_hi_hit);
    div_req.num   = (state == S_SMUL) ? soil_prod : bat_prod;
    div_req.den   = (state == S_SMUL) ? soil_den  : bat_den;
  end

  // smoothing: weighted sum, then divide by ten through a reciprocal
  always_comb begin
    sm_sel  = (state == S_SUM1) || (state == S_RND1);
    sm_new  = sm_sel ? battery_map      : soil_map;
    sm_old  = sm_sel ? battery_smoothed : soil_smoothed;
    sm_diff = (sm_new >= sm_old) ? (sm_new - sm_old) : (sm_old - sm_new);
    sm_fast = sm_diff > JUMP_LIMIT;
    if (sm_fast) begin
      sm_sum = (SUM_W'(sm_new) << 3) + SUM_W'(sm_new) + SUM_W'(sm_old);
    end else begin
      sm_sum = (SUM_W'(sm_new) << 1) + (SUM_W'(sm_old) << 3);
    end
    sm_scaled = SCALE_W'(sum) * SCALE_W'(RECIP_TENTH);
    sm_result = sm_scaled[RECIP_SHIFT +: LEVEL_W];
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_SMUL;
      S_SMUL: state_next = soil_empty ? S_BMUL : S_SDIV;
      S_SDIV: if (div_rsp.done) state_next = S_BMUL;
      S_BMUL: state_next = (bat_lo_hit || bat_hi_hit) ? S_SUM0 : S_BDIV;
      S_BDIV: if (div_rsp.done) state_next = S_SUM0;
      S_SUM0: state_next = S_RND0;
      S_RND0: state_next = S_SUM1;
      S_SUM1: state_next = S_RND1;
      S_RND1: state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      soil_wet_limit   <= '0;
      soil_dry_limit   <= 13'd4095;
      battery_in_low   <= '0;
      battery_in_high  <= 13'd4095;
      battery_out_low  <= '0;
      battery_out_high <= 10'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOIL_WET:   soil_wet_limit   <= cfg_data;
        CFG_SOIL_DRY:   soil_dry_limit   <= cfg_data;
        CFG_BAT_IN_LO:  battery_in_low   <= cfg_data;
        CFG_BAT_IN_HI:  battery_in_high  <= cfg_data;
        CFG_BAT_OUT_LO: battery_out_low  <= cfg_data[LEVEL_W-1:0];
        CFG_BAT_OUT_HI: battery_out_high <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // smoothing state
  always_ff @(posedge clk) begin
    if (rst) begin
      soil_smoothed    <= '0;
      battery_smoothed <= '0;
    end else if (state == S_RND0) begin
      soil_smoothed <= sm_result;
    end else if (state == S_RND1) begin
      battery_smoothed <= sm_result;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      soil_mv    <= s_tdata[MV_W-1:0];
      battery_mv <= s_tdata[2*MV_W-1:MV_W];
    end
    if (state == S_SMUL && soil_empty) begin
      soil_map <= SOIL_FULL;
    end else if (state == S_SDIV && div_rsp.done) begin
      soil_map <= SOIL_FULL - div_rsp.quot;
    end
    if (state == S_BMUL) begin
      bat_neg <= out_neg;
      if (bat_lo_hit) begin
        battery_map <= battery_out_low;
      end else if (bat_hi_hit) begin
        battery_map <= battery_out_high;
      end
    end else if (state == S_BDIV && div_rsp.done) begin
      battery_map <= bat_div_level;
    end
    if (state == S_SUM0 || state == S_SUM1) begin
      sum <= sm_sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0, battery_smoothed, soil_smoothed};
    end
  end

  smas_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SMUL))
    else $error("accepted transaction did not start the sequence");

  a_soil_quot_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SDIV && div_rsp.done) |-> (div_rsp.quot <= SOIL_FULL))
    else $error("moisture quotient above full scale");

  a_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_SDIV || state == S_BDIV))
    else $error("divider result arrived outside a divide state");

endmodule

[bench/sensor_map_and_adaptive_smoothing_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_map_and_adaptive_smoothing_tb
// Drives moisture/battery reading pairs into the block and checks each
// smoothed level pair against a cycle-free model of the range maps and the
// two smoothing registers. Directed cases cover the clamp bounds, empty and
// inverted windows, reversed and oversized output ranges and ignored register
// writes; random phases then sweep many calibration settings with random
// idling on both streams, except in the last phase.
// ----------------------------------------------------------------------------
module sensor_map_and_adaptive_smoothing_tb;
  import smas_pkg::*;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam int SETTLE_CYCLES  = 40;     // above the worst-case latency of the block
  localparam int PHASE_ITEMS    = 200;
  localparam int RANDOM_PHASES  = 7;
  localparam int ALPHA_FAST     = 9;
  localparam int ALPHA_SLOW     = 2;
  localparam int ALPHA_DEN      = 10;
  localparam int MV_MAX         = 8191;

  typedef struct packed {
    logic [LEVEL_W-1:0] battery;
    logic [LEVEL_W-1:0] soil;
  } level_pair_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [31:0]          s_tdata;   // [12:0] soil_mv, [25:13] battery_mv
  logic                 m_tvalid;
  logic                 m_tready;
  logic [23:0]          m_tdata;   // [9:0] soil_level, [19:10] battery_level
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MV_W-1:0]      cfg_data;

  // model copy of the calibration registers
  logic [MV_W-1:0]      soil_wet_mv;
  logic [MV_W-1:0]      soil_dry_mv;
  logic [MV_W-1:0]      bat_in_lo_mv;
  logic [MV_W-1:0]      bat_in_hi_mv;
  logic [LEVEL_W-1:0]   bat_out_lo;
  logic [LEVEL_W-1:0]   bat_out_hi;

  // model copy of the smoothing registers
  logic [LEVEL_W-1:0]   soil_avg;
  logic [LEVEL_W-1:0]   battery_avg;

  level_pair_t          pending_levels[$];
  int unsigned          error_count;
  int unsigned          readings_sent;
  int unsigned          levels_checked;
  int unsigned          settings_applied;
  bit                   quiet;
  int                   out_stall_left;
  logic [MV_W-1:0]      last_soil_mv;
  logic [MV_W-1:0]      last_bat_mv;

  sensor_map_and_adaptive_smoothing DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit, far above the slowest legal run
  initial begin
    #20ms;
    $display("sensor_map_and_adaptive_smoothing verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- model

  // inverse moisture map onto 0..1000, full scale when the window is empty
  function automatic logic [LEVEL_W-1:0] map_moisture(input logic [MV_W-1:0] mv);
    int lo;
    int hi;
    int v;
    lo = soil_wet_mv;
    hi = soil_dry_mv;
    v  = mv;
    if (hi <= lo) return SOIL_FULL;
    if (v < lo) v = lo;
    else if (v > hi) v = hi;
    return LEVEL_W'(1000 - ((v - lo) * 1000) / (hi - lo));
  endfunction

  // linear battery map; reversed output ranges truncate toward zero
  function automatic logic [LEVEL_W-1:0] map_bat_level(input logic [MV_W-1:0] mv);
    int num;
    int span;
    int lvl;
    if (mv <= bat_in_lo_mv) return bat_out_lo;
    if (mv >= bat_in_hi_mv) return bat_out_hi;
    num  = (int'(mv) - int'(bat_in_lo_mv)) * (int'(bat_out_hi) - int'(bat_out_lo));
    span = int'(bat_in_hi_mv) - int'(bat_in_lo_mv);
    lvl  = num / span + int'(bat_out_lo);
    return lvl[LEVEL_W-1:0];
  endfunction

  // one smoothing step; fast alpha on a jump above the limit
  function automatic logic [LEVEL_W-1:0] smooth_level(input logic [LEVEL_W-1:0] prev,
                                                      input logic [LEVEL_W-1:0] fresh);
    int diff;
    int alpha;
    int mix;
    diff  = int'(fresh) - int'(prev);
    if (diff < 0) diff = -diff;
    alpha = (diff > int'(JUMP_LIMIT)) ? ALPHA_FAST : ALPHA_SLOW;
    mix   = (alpha * int'(fresh) + (ALPHA_DEN - alpha) * int'(prev)) / ALPHA_DEN;
    return mix[LEVEL_W-1:0];
  endfunction

  // ---------------------------------------------------------------- output side

  // random result stall bursts, none in the quiet phase
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      m_tready = 1'b0;
      out_stall_left = out_stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_tready = 1'b0;
      out_stall_left = $urandom_range(1, 5) - 1;
    end else begin
      m_tready = 1'b1;
    end
  end

  // compare every result transaction with the oldest prediction
  always @(posedge clk) begin
    level_pair_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_levels.size() == 0) begin
        $error("unexpected result: soil_level %0d battery_level %0d",
               m_tdata[9:0], m_tdata[19:10]);
        error_count++;
      end else begin
        want = pending_levels.pop_front();
        levels_checked++;
        if (m_tdata[9:0] !== want.soil) begin
          $error("soil_level: expected %0d, got %0d", want.soil, m_tdata[9:0]);
          error_count++;
        end
        if (m_tdata[19:10] !== want.battery) begin
          $error("battery_level: expected %0d, got %0d", want.battery, m_tdata[19:10]);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // one register write; model follows the same decode
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      CFG_SOIL_WET:   soil_wet_mv  = val;
      CFG_SOIL_DRY:   soil_dry_mv  = val;
      CFG_BAT_IN_LO:  bat_in_lo_mv = val;
      CFG_BAT_IN_HI:  bat_in_hi_mv = val;
      CFG_BAT_OUT_LO: bat_out_lo   = val[LEVEL_W-1:0];
      CFG_BAT_OUT_HI: bat_out_hi   = val[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  // wait until every prediction has been matched and the block is idle
  task automatic settle_block();
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_calibration(input logic [MV_W-1:0] wet, input logic [MV_W-1:0] dry,
                                   input logic [MV_W-1:0] in_lo, input logic [MV_W-1:0] in_hi,
                                   input logic [MV_W-1:0] out_lo,
                                   input logic [MV_W-1:0] out_hi);
    settle_block();
    write_reg(CFG_SOIL_WET, wet);
    write_reg(CFG_SOIL_DRY, dry);
    write_reg(CFG_BAT_IN_LO, in_lo);
    write_reg(CFG_BAT_IN_HI, in_hi);
    write_reg(CFG_BAT_OUT_LO, out_lo);
    write_reg(CFG_BAT_OUT_HI, out_hi);
    settings_applied++;
  endtask

  // one reading transaction; prediction is made at the accepting edge
  task automatic send_reading(input logic [MV_W-1:0] soil_mv, input logic [MV_W-1:0] bat_mv);
    level_pair_t lv;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {6'd0, bat_mv, soil_mv};
    while (1) begin
      @(posedge clk);
      if (s_tready) break;
    end
    soil_avg    = smooth_level(soil_avg, map_moisture(soil_mv));
    battery_avg = smooth_level(battery_avg, map_bat_level(bat_mv));
    lv.soil     = soil_avg;
    lv.battery  = battery_avg;
    pending_levels.push_back(lv);
    readings_sent++;
    last_soil_mv = soil_mv;
    last_bat_mv  = bat_mv;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // ---------------------------------------------------------------- random helpers

  function automatic logic [MV_W-1:0] pick_bound();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return MV_W'(MV_MAX);
      2:       return MV_W'(4095);
      default: return MV_W'($urandom_range(0, MV_MAX));
    endcase
  endfunction

  function automatic logic [MV_W-1:0] pick_out_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return MV_W'(1000);
      2:       return MV_W'(1023);
      default: return MV_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // reading near a window edge, near the last one, or anywhere
  function automatic logic [MV_W-1:0] pick_mv(input logic [MV_W-1:0] lo,
                                              input logic [MV_W-1:0] hi,
                                              input logic [MV_W-1:0] prev);
    int v;
    case ($urandom_range(0, 3))
      0: v = (($urandom_range(0, 1) == 0) ? int'(lo) : int'(hi)) + $urandom_range(0, 4) - 2;
      1: v = int'(prev) + $urandom_range(0, 200) - 100;
      default: v = $urandom_range(0, MV_MAX);
    endcase
    if (v < 0) v = 0;
    if (v > MV_MAX) v = MV_MAX;
    return MV_W'(v);
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_reading(13'd0, 13'd0);
    send_reading(13'd8191, 13'd8191);
    send_reading(13'd2048, 13'd2047);
    send_reading(13'd4095, 13'd4095);
    send_reading(13'd1, 13'd4094);
    send_reading(13'd4096, 13'd4096);
  endtask

  task automatic test_soil_window();
    apply_calibration(13'd1000, 13'd3000, 13'd0, 13'd4095, 13'd0, 13'd100);
    send_reading(13'd999, 13'd100);
    send_reading(13'd1000, 13'd200);
    send_reading(13'd2000, 13'd300);
    send_reading(13'd3000, 13'd400);
    send_reading(13'd3001, 13'd500);
    // single-point window counts as empty
    apply_calibration(13'd2000, 13'd2000, 13'd0, 13'd4095, 13'd0, 13'd100);
    send_reading(13'd5000, 13'd600);
    // inverted window
    apply_calibration(13'd8191, 13'd0, 13'd0, 13'd4095, 13'd0, 13'd100);
    send_reading(13'd0, 13'd700);
    // widest window
    apply_calibration(13'd0, 13'd8191, 13'd0, 13'd4095, 13'd0, 13'd100);
    send_reading(13'd8191, 13'd800);
    send_reading(13'd0, 13'd900);
  endtask

  task automatic test_battery_map();
    // reversed and oversized output range
    apply_calibration(13'd0, 13'd4095, 13'd100, 13'd8000, 13'd1023, 13'd0);
    send_reading(13'd100, 13'd100);
    send_reading(13'd200, 13'd101);
    send_reading(13'd300, 13'd4000);
    send_reading(13'd400, 13'd7999);
    send_reading(13'd500, 13'd8000);
    // zero-width input window: low bound test wins
    apply_calibration(13'd0, 13'd4095, 13'd3000, 13'd3000, 13'd5, 13'd1000);
    send_reading(13'd600, 13'd2999);
    send_reading(13'd700, 13'd3000);
    send_reading(13'd800, 13'd3001);
    // inverted input window
    apply_calibration(13'd0, 13'd4095, 13'd6000, 13'd2000, 13'd0, 13'd1023);
    send_reading(13'd900, 13'd4000);
  endtask

  task automatic test_spare_index();
    settle_block();
    write_reg(CFG_SPARE_6, 13'h1fff);
    write_reg(CFG_SPARE_7, 13'h0000);
    send_reading(13'd1234, 13'd5000);
    send_reading(13'd7000, 13'd6500);
  endtask

  task automatic test_random_phases();
    logic [MV_W-1:0] s_mv;
    logic [MV_W-1:0] b_mv;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: apply_calibration(13'd0, 13'd8191, 13'd0, 13'd8191, 13'd0, 13'd1000);
        1: apply_calibration(13'd8191, 13'd0, 13'd8191, 13'd0, 13'd1023, 13'd0);
        2: apply_calibration(13'd500, 13'd3500, 13'd2800, 13'd4200, 13'd1000, 13'd0);
        default: apply_calibration(pick_bound(), pick_bound(), pick_bound(), pick_bound(),
                                   pick_out_level(), pick_out_level());
      endcase
      // last phase runs both streams back to back
      if (ph == RANDOM_PHASES - 1) begin
        settle_block();
        quiet = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        s_mv = pick_mv(soil_wet_mv, soil_dry_mv, last_soil_mv);
        b_mv = pick_mv(bat_in_lo_mv, bat_in_hi_mv, last_bat_mv);
        send_reading(s_mv, b_mv);
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst              = 1'b1;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    m_tready         = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    soil_wet_mv      = 13'd0;
    soil_dry_mv      = 13'd4095;
    bat_in_lo_mv     = 13'd0;
    bat_in_hi_mv     = 13'd4095;
    bat_out_lo       = 10'd0;
    bat_out_hi       = 10'd100;
    soil_avg         = '0;
    battery_avg      = '0;
    error_count      = 0;
    readings_sent    = 0;
    levels_checked   = 0;
    settings_applied = 0;
    quiet            = 1'b0;
    out_stall_left   = 0;
    last_soil_mv     = '0;
    last_bat_mv      = '0;

    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_soil_window();
    test_battery_map();
    test_spare_index();
    test_random_phases();

    settle_block();

    $display("Checked %0d level pairs from %0d readings over %0d calibration settings,",
             levels_checked, readings_sent, settings_applied);
    $display("including empty windows, reversed ranges and back-to-back streaming.");
    if (error_count == 0 && pending_levels.size() == 0) begin
      $display("sensor_map_and_adaptive_smoothing verification clean");
    end else begin
      $display("sensor_map_and_adaptive_smoothing verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/smas_pkg.sv
design/smas_div.sv
design/sensor_map_and_adaptive_smoothing.sv
bench/sensor_map_and_adaptive_smoothing_tb.sv
